[rtl/ackrt_pkg.sv]
package ackrt_pkg;

  localparam int ACK_WAIT_W   = 16;
  localparam int MAX_RETRY_W  = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int ID_W         = 8;
  localparam int DEST_W       = 2;
  localparam int LEN_W        = 6;
  localparam int TIME_W       = 32;
  localparam int SLOT_OUT_W   = 4;
  localparam int HITS_W       = 5;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_LINK = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [DEST_W-1:0] DEST_ONE  = 2'd0;
  localparam logic [DEST_W-1:0] DEST_TWO  = 2'd1;
  localparam logic [DEST_W-1:0] DEST_BOTH = 2'd2;
  localparam logic [DEST_W-1:0] DEST_NONE = 2'd3;

  localparam logic CFG_ACK_WAIT    = 1'b0;
  localparam logic CFG_MAX_RETRIES = 1'b1;

  localparam logic [ACK_WAIT_W-1:0]  ACK_WAIT_RESET    = 16'd100;
  localparam logic [MAX_RETRY_W-1:0] MAX_RETRIES_RESET = 8'd25;
  localparam logic [LEN_W-1:0]       MAX_LENGTH        = 6'd31;
  localparam logic [ID_W-1:0]        LAST_ID           = 8'd254;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [DEST_W-1:0]      dest;
    logic [LEN_W-1:0]       size;
    logic [TIME_W-1:0]      last_send;
    logic [MAX_RETRY_W-1:0] tries;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } stat_t;

endpackage

[rtl/ack_retransmit_table.sv]
// channel  | handshake                    | payload
// ---------+------------------------------+---------------------------------------------
// item     | item_valid / item_stall      | opcode target length ack_id link_select
//          |                              | link_on now_time
// result   | result_valid / result_stall  | accepted slot message_id send_now
//          |                              | send_target send_length gave_up ack_hits
// config   | cfg_write                    | cfg_index cfg_data
//
// Add and link status words go from ST_IDLE to ST_FINISH, which loads the result register.
// Ack and tick words scan the slot RAM one slot per cycle, up to all SLOT_COUNT slots;
// a tick ends at its first send hit or at the first live entry on a down link.
// Synchronous reset clears valid bits and pointers and brings both links up; no clearing pass.
// The block takes a new item while the last result waits under result_stall,
// and holds that item's result until the output register frees.
module ack_retransmit_table
  import ackrt_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [1:0]              opcode,
  input  logic [DEST_W-1:0]       target,
  input  logic [LEN_W-1:0]        length,
  input  logic [ID_W-1:0]         ack_id,
  input  logic                    link_select,
  input  logic                    link_on,
  input  logic [TIME_W-1:0]       now_time,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic                    accepted,
  output logic [SLOT_OUT_W-1:0]   slot,
  output logic [ID_W-1:0]         message_id,
  output logic                    send_now,
  output logic [DEST_W-1:0]       send_target,
  output logic [LEN_W-1:0]        send_length,
  output logic                    gave_up,
  output logic [HITS_W-1:0]       ack_hits
);

  cmd_t  cmd;
  stat_t stat;

  ackrt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .opcode     (opcode),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  ackrt_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .target       (target),
    .length       (length),
    .ack_id       (ack_id),
    .link_select  (link_select),
    .link_on      (link_on),
    .now_time     (now_time),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted),
    .slot         (slot),
    .message_id   (message_id),
    .send_now     (send_now),
    .send_target  (send_target),
    .send_length  (send_length),
    .gave_up      (gave_up),
    .ack_hits     (ack_hits)
  );

endmodule

[rtl/ackrt_ram.sv]
module ackrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/ackrt_ctrl.sv]
module ackrt_ctrl
  import ackrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [1:0] opcode,
  output logic       item_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (opcode inside {OP_ACK, OP_TICK}) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.take   = item_valid;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.load = !stat.out_busy;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

endmodule

[rtl/ackrt_dp.sv]
module ackrt_dp
  import ackrt_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]              opcode,
  input  logic [DEST_W-1:0]       target,
  input  logic [LEN_W-1:0]        length,
  input  logic [ID_W-1:0]         ack_id,
  input  logic                    link_select,
  input  logic                    link_on,
  input  logic [TIME_W-1:0]       now_time,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic                    accepted,
  output logic [SLOT_OUT_W-1:0]   slot,
  output logic [ID_W-1:0]         message_id,
  output logic                    send_now,
  output logic [DEST_W-1:0]       send_target,
  output logic [LEN_W-1:0]        send_length,
  output logic                    gave_up,
  output logic [HITS_W-1:0]       ack_hits
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int EW = $bits(entry_t);

  logic [ACK_WAIT_W-1:0]  ack_wait;
  logic [MAX_RETRY_W-1:0] max_retries;
  logic [SLOT_COUNT-1:0]  valid;
  logic [IW-1:0]          write_slot;
  logic [ID_W-1:0]        next_id;
  logic                   link_one_up;
  logic                   link_two_up;

  // latched item for the scan
  logic [1:0]             op_q;
  logic [ID_W-1:0]        ack_id_q;
  logic [TIME_W-1:0]      now_q;
  logic [IW-1:0]          eval_idx;

  // result being built
  logic                   res_accepted;
  logic [SLOT_OUT_W-1:0]  res_slot;
  logic [ID_W-1:0]        res_id;
  logic                   res_send;
  logic [DEST_W-1:0]      res_target;
  logic [LEN_W-1:0]       res_length;
  logic                   res_gave_up;
  logic [HITS_W-1:0]      res_hits;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  entry_t                 ram_wdata;
  logic [IW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rbits;
  entry_t                 cur;

  logic                   add_ok;
  logic                   last_idx;
  logic                   cur_valid;
  logic                   blocked;
  logic                   elapsed;
  logic                   send_hit;
  logic                   ack_hit;
  logic [MAX_RETRY_W-1:0] tries_new;
  logic                   quit;
  logic                   tick_scan;

  assign cur       = entry_t'(ram_rbits);
  assign add_ok    = (opcode == OP_ADD) && (length <= MAX_LENGTH);
  assign last_idx  = (eval_idx == IW'(SLOT_COUNT - 1));
  assign cur_valid = valid[eval_idx];
  assign tick_scan = (op_q == OP_TICK);
  assign blocked   = ((cur.dest == DEST_ONE) && !link_one_up) ||
                     ((cur.dest == DEST_TWO) && !link_two_up);
  assign elapsed   = (now_q - cur.last_send) > {{(TIME_W-ACK_WAIT_W){1'b0}}, ack_wait};
  assign send_hit  = cmd.step && tick_scan && cur_valid && !blocked && elapsed;
  assign ack_hit   = cmd.step && !tick_scan && (cur.id == ack_id_q);
  assign tries_new = cur.tries + 8'd1;
  assign quit      = (tries_new >= max_retries);

  assign stat.scan_done = last_idx || (tick_scan && cur_valid && (blocked || elapsed));
  assign stat.out_busy  = result_valid && result_stall;

  assign ram_raddr = (cmd.take || last_idx) ? '0 : IW'(eval_idx + 1'b1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = write_slot;
    ram_wdata = '0;
    if (cmd.take && add_ok) begin
      ram_we         = 1'b1;
      ram_wdata.id   = next_id;
      ram_wdata.dest = target;
      ram_wdata.size = LEN_W'(length + 1'b1);
    end else if (send_hit) begin
      ram_we              = 1'b1;
      ram_waddr           = eval_idx;
      ram_wdata           = cur;
      ram_wdata.last_send = now_q;
      ram_wdata.tries     = tries_new;
    end
  end

  ackrt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rbits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait    <= ACK_WAIT_RESET;
      max_retries <= MAX_RETRIES_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_ACK_WAIT) begin
        ack_wait <= cfg_data;
      end else begin
        max_retries <= cfg_data[MAX_RETRY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      write_slot  <= '0;
      next_id     <= '0;
      link_one_up <= 1'b1;
      link_two_up <= 1'b1;
    end else begin
      if (cmd.take && add_ok) begin
        valid[write_slot] <= (target != DEST_NONE);
        write_slot <= (write_slot == IW'(SLOT_COUNT - 1)) ? '0 : IW'(write_slot + 1'b1);
        next_id    <= (next_id == LAST_ID) ? '0 : ID_W'(next_id + 1'b1);
      end
      if (cmd.take && (opcode == OP_LINK)) begin
        if (link_select) begin
          link_two_up <= link_on;
        end else begin
          link_one_up <= link_on;
        end
      end
      if (ack_hit || (send_hit && quit)) begin
        valid[eval_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q         <= opcode;
      ack_id_q     <= ack_id;
      now_q        <= now_time;
      eval_idx     <= '0;
      res_accepted <= add_ok;
      res_slot     <= add_ok ? SLOT_OUT_W'(write_slot) : '0;
      res_id       <= add_ok ? next_id : '0;
      res_send     <= 1'b0;
      res_target   <= '0;
      res_length   <= '0;
      res_gave_up  <= 1'b0;
      res_hits     <= '0;
    end else if (cmd.step) begin
      eval_idx <= IW'(eval_idx + 1'b1);
      if (ack_hit && cur_valid) begin
        res_hits <= HITS_W'(res_hits + 1'b1);
      end
      if (send_hit) begin
        res_slot    <= SLOT_OUT_W'(eval_idx);
        res_id      <= cur.id;
        res_send    <= 1'b1;
        res_target  <= cur.dest;
        res_length  <= cur.size;
        res_gave_up <= quit;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accepted    <= res_accepted;
      slot        <= res_slot;
      message_id  <= res_id;
      send_now    <= res_send;
      send_target <= res_target;
      send_length <= res_length;
      gave_up     <= res_gave_up;
      ack_hits    <= res_hits;
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import ackrt_pkg::*;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 250000;
  localparam int WORDS_PER_PHASE = 130;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [DEST_W-1:0] target;
    logic [LEN_W-1:0]  length;
    logic [ID_W-1:0]   ack_id;
    logic              link_select;
    logic              link_on;
    logic [TIME_W-1:0] now_time;
  } word_t;

  typedef struct packed {
    logic                  accepted;
    logic [SLOT_OUT_W-1:0] slot;
    logic [ID_W-1:0]       message_id;
    logic                  send_now;
    logic [DEST_W-1:0]     send_target;
    logic [LEN_W-1:0]      send_length;
    logic                  gave_up;
    logic [HITS_W-1:0]     ack_hits;
  } result_t;

  // Mirror of the retransmit table plus the queue of results still owed.
  class retx_tracker;
    bit                   live [SLOTS];
    bit [ID_W-1:0]        tag [SLOTS];
    bit [DEST_W-1:0]      dest [SLOTS];
    bit [LEN_W-1:0]       send_len [SLOTS];
    bit [TIME_W-1:0]      sent_at [SLOTS];
    bit [MAX_RETRY_W-1:0] tries [SLOTS];
    int                   wr_slot;
    bit [ID_W-1:0]        id_next;
    bit                   link_one_up;
    bit                   link_two_up;
    bit [ACK_WAIT_W-1:0]  wait_limit;
    bit [MAX_RETRY_W-1:0] retry_limit;
    result_t              due_results[$];
    int errors, checked, words, sends, give_ups, ack_total, halts, rejects;

    function new();
      foreach (live[i]) begin
        live[i] = 1'b0;
        tag[i] = '0;
        dest[i] = '0;
        send_len[i] = '0;
        sent_at[i] = '0;
        tries[i] = '0;
      end
      wr_slot = 0;
      id_next = '0;
      link_one_up = 1'b1;
      link_two_up = 1'b1;
      wait_limit = ACK_WAIT_RESET;
      retry_limit = MAX_RETRIES_RESET;
    endfunction

    function void set_reg(logic idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ACK_WAIT)
        wait_limit = data;
      else
        retry_limit = data[MAX_RETRY_W-1:0];
    endfunction

    function void note_word(word_t w);
      result_t r;
      int hits;
      bit [TIME_W-1:0] age;
      bit quit;
      r = '0;
      words++;
      case (w.opcode)
        OP_ADD: begin
          if (w.length <= MAX_LENGTH) begin
            r.accepted = 1'b1;
            r.slot = wr_slot[SLOT_OUT_W-1:0];
            r.message_id = id_next;
            live[wr_slot] = (w.target != DEST_NONE);
            tag[wr_slot] = id_next;
            dest[wr_slot] = w.target;
            send_len[wr_slot] = w.length + 1'b1;
            sent_at[wr_slot] = '0;
            tries[wr_slot] = '0;
            wr_slot = (wr_slot + 1) % SLOTS;
            id_next = (id_next == LAST_ID) ? '0 : id_next + 1'b1;
          end else begin
            rejects++;
          end
        end
        OP_ACK: begin
          hits = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (tag[i] == w.ack_id) begin
              if (live[i])
                hits++;
              live[i] = 1'b0;
            end
          end
          r.ack_hits = HITS_W'(hits);
          ack_total += hits;
        end
        OP_LINK: begin
          if (w.link_select == 1'b0)
            link_one_up = w.link_on;
          else
            link_two_up = w.link_on;
        end
        default: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!live[i])
              continue;
            // first live entry on a down link blocks everything behind it
            if ((dest[i] == DEST_ONE && !link_one_up) ||
                (dest[i] == DEST_TWO && !link_two_up)) begin
              halts++;
              break;
            end
            age = w.now_time - sent_at[i];
            if (age > wait_limit) begin
              tries[i] = tries[i] + 1'b1;
              quit = (tries[i] >= retry_limit);
              if (quit) begin
                live[i] = 1'b0;
                give_ups++;
              end
              sent_at[i] = w.now_time;
              r.slot = i[SLOT_OUT_W-1:0];
              r.message_id = tag[i];
              r.send_now = 1'b1;
              r.send_target = dest[i];
              r.send_length = send_len[i];
              r.gave_up = quit;
              sends++;
              break;
            end
          end
        end
      endcase
      due_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("error: %s", msg);
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = due_results.pop_front();
      compare("accepted", 32'(got.accepted), 32'(want.accepted));
      compare("slot", 32'(got.slot), 32'(want.slot));
      compare("message_id", 32'(got.message_id), 32'(want.message_id));
      compare("send_now", 32'(got.send_now), 32'(want.send_now));
      compare("send_target", 32'(got.send_target), 32'(want.send_target));
      compare("send_length", 32'(got.send_length), 32'(want.send_length));
      compare("gave_up", 32'(got.gave_up), 32'(want.gave_up));
      compare("ack_hits", 32'(got.ack_hits), 32'(want.ack_hits));
      checked++;
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic [1:0]             opcode = OP_ADD;
  logic [DEST_W-1:0]      target = '0;
  logic [LEN_W-1:0]       length = '0;
  logic [ID_W-1:0]        ack_id = '0;
  logic                   link_select = 1'b0;
  logic                   link_on = 1'b0;
  logic [TIME_W-1:0]      now_time = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b1;
  logic                   accepted;
  logic [SLOT_OUT_W-1:0]  slot;
  logic [ID_W-1:0]        message_id;
  logic                   send_now;
  logic [DEST_W-1:0]      send_target;
  logic [LEN_W-1:0]       send_length;
  logic                   gave_up;
  logic [HITS_W-1:0]      ack_hits;

  retx_tracker book = new();
  int          cycle_count = 0;
  int          hold_len = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  logic [TIME_W-1:0] clock_ms = 32'd2000;

  int wait_set [6] = '{0, 65535, 3, 40, 100, 10};
  int retry_set [6] = '{1, 255, 2, 0, 25, 5};

  ack_retransmit_table #(.SLOT_COUNT(SLOTS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .target       (target),
    .length       (length),
    .ack_id       (ack_id),
    .link_select  (link_select),
    .link_on      (link_on),
    .now_time     (now_time),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted),
    .slot         (slot),
    .message_id   (message_id),
    .send_now     (send_now),
    .send_target  (send_target),
    .send_length  (send_length),
    .gave_up      (gave_up),
    .ack_hits     (ack_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results owed", cycle_count,
             book.due_results.size());
    $display("testbench: FAIL");
    $finish;
  end

  function automatic word_t mk(logic [1:0] op, logic [DEST_W-1:0] tgt, logic [LEN_W-1:0] len,
                               logic [ID_W-1:0] id, logic sel, logic on, logic [TIME_W-1:0] t);
    word_t w;
    w.opcode = op;
    w.target = tgt;
    w.length = len;
    w.ack_id = id;
    w.link_select = sel;
    w.link_on = on;
    w.now_time = t;
    return w;
  endfunction

  // Mostly sane traffic: adds that fit, ticks on an advancing clock, acks of live ids.
  function word_t random_word(int step_max);
    word_t w;
    int pick;
    w.target = DEST_W'($urandom);
    w.length = LEN_W'($urandom);
    w.ack_id = ID_W'($urandom);
    w.link_select = 1'($urandom);
    w.link_on = 1'($urandom);
    w.now_time = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w.opcode = OP_ADD;
      if ($urandom_range(0, 15) != 0)
        w.target = DEST_W'($urandom_range(0, 2));
      if ($urandom_range(0, 7) != 0)
        w.length = LEN_W'($urandom_range(0, MAX_LENGTH));
    end else if (pick < 75) begin
      w.opcode = OP_TICK;
      if ($urandom_range(0, 19) == 0)
        clock_ms = $urandom;
      else
        clock_ms = clock_ms + $urandom_range(0, step_max);
      w.now_time = clock_ms;
    end else if (pick < 93) begin
      w.opcode = OP_ACK;
      pick = $urandom_range(0, 9);
      if (pick < 7)
        w.ack_id = ID_W'((int'(book.id_next) + 254 - $urandom_range(0, 15)) % 255);
      else if (pick == 7)
        w.ack_id = 8'hFF;
    end else begin
      w.opcode = OP_LINK;
      w.link_on = ($urandom_range(0, 2) != 0);
    end
    return w;
  endfunction

  task send_word(word_t w);
    int gap;
    if ($urandom_range(0, 31) == 0)
      send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk);
      item_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    opcode = w.opcode;
    target = w.target;
    length = w.length;
    ack_id = w.ack_id;
    link_select = w.link_select;
    link_on = w.link_on;
    now_time = w.now_time;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    book.note_word(w);
  endtask

  task write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    book.set_reg(idx, data);
  endtask

  task settle();
    @(negedge clk);
    item_valid = 1'b0;
    while (book.due_results.size() != 0) @(posedge clk);
  endtask

  // result side
  initial begin
    int gap;
    result_t got;
    while (rst) @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        @(negedge clk);
        result_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      if ($urandom_range(0, 31) == 0)
        recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        @(negedge clk);
        result_stall = 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      result_stall = 1'b0;
      do @(posedge clk); while (!result_valid);
      got.accepted = accepted;
      got.slot = slot;
      got.message_id = message_id;
      got.send_now = send_now;
      got.send_target = send_target;
      got.send_length = send_length;
      got.gave_up = gave_up;
      got.ack_hits = ack_hits;
      book.check_result(got);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings (wait 100, limit 25)
    send_word(mk(OP_TICK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_ACK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_ADD, DEST_ONE, 6'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_ADD, DEST_TWO, 6'd31, 8'd0, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_ADD, DEST_BOTH, 6'd63, 8'd0, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_ADD, DEST_NONE, 6'd5, 8'd0, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_ADD, DEST_BOTH, 6'd32, 8'd0, 1'b0, 1'b0, 32'd0));
    // age equal to the wait is not enough, one more is
    send_word(mk(OP_TICK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd100));
    send_word(mk(OP_TICK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd101));
    send_word(mk(OP_LINK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_TICK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd500));
    send_word(mk(OP_ADD, DEST_BOTH, 6'd7, 8'd0, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_LINK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b1, 32'd0));
    send_word(mk(OP_LINK, 2'd0, 6'd0, 8'd0, 1'b1, 1'b0, 32'd0));
    send_word(mk(OP_TICK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd1000));
    send_word(mk(OP_TICK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd1000));
    send_word(mk(OP_LINK, 2'd0, 6'd0, 8'd0, 1'b1, 1'b1, 32'd0));
    send_word(mk(OP_TICK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd1000));
    send_word(mk(OP_ACK, 2'd0, 6'd0, 8'hFF, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_ACK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    // time wraps past 2^32
    send_word(mk(OP_TICK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_word(mk(OP_TICK, 2'd0, 6'd0, 8'd0, 1'b0, 1'b0, 32'h0000_0010));
    send_word(mk(OP_ACK, 2'd0, 6'd0, 8'd2, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_ACK, 2'd0, 6'd0, 8'd3, 1'b0, 1'b0, 32'd0));
    send_word(mk(OP_ACK, 2'd0, 6'd0, 8'd1, 1'b0, 1'b0, 32'd0));

    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(CFG_ACK_WAIT, CFG_DATA_W'(wait_set[p]));
      write_reg(CFG_MAX_RETRIES, CFG_DATA_W'(retry_set[p]));
      // long output hold-off so the block backs up into item_stall
      if (p == 1)
        hold_len = 300;
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        send_word(random_word(2 * wait_set[p] + 4));
    end

    settle();
    repeat (40) @(posedge clk);
    if (book.due_results.size() != 0)
      book.report("results still owed at end of run");
    $display("summary: %0d words over 7 register settings, %0d results checked, %0d errors",
             book.words, book.checked, book.errors);
    $display("summary: %0d sends, %0d retired at limit, %0d acked, %0d halted, %0d rejected",
             book.sends, book.give_ups, book.ack_total, book.halts, book.rejects);
    if (book.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
